@@ src/twm_pkg.sv @@
// Package for the tiny word machine: item and result types, opcodes,
// state codes, character constants and default sizes.
// No dependencies.
package twm_pkg;

    localparam int MEM_WORDS   = 100;
    localparam int BLOCK_WORDS = 10;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_L       = 8'h4C;
    localparam logic [7:0] CH_S       = 8'h53;
    localparam logic [7:0] CH_C       = 8'h43;
    localparam logic [7:0] CH_B       = 8'h42;
    localparam logic [7:0] CH_H       = 8'h48;
    localparam logic [7:0] CH_G       = 8'h47;
    localparam logic [7:0] CH_P       = 8'h50;

    typedef enum logic [1:0] {
        OPC_LOAD  = 2'd0,
        OPC_EXEC  = 2'd1,
        OPC_CARD  = 2'd2,
        OPC_CLEAR = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FETCH,
        ST_OPER,
        ST_PRINT,
        ST_PRINT_NL,
        ST_HALT_NL,
        ST_CARD
    } state_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [6:0]  address;
        logic [31:0] word;
        logic [7:0]  card_byte;
    } cmd_t;

    typedef struct packed {
        logic        printer_valid;
        logic [7:0]  printer_byte;
        logic        last;
        logic        halted;
        logic        waiting_card;
        logic        fault;
        logic [6:0]  counter_value;
        logic        flag_value;
        logic [31:0] register_value;
    } rsp_t;

endpackage

@@ src/twm_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module twm_ram #(
    parameter int W  = 32,
    parameter int D  = 100,
    parameter int AW = $clog2(D)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  q
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            q <= mem[raddr];
        end
    end

endmodule

@@ src/tiny_word_machine_cpu.sv @@
// Top level of the tiny word machine: sequencer, machine registers and word memory.
// Depends on twm_pkg and twm_ram.
//
// Commands arrive on cmd (cmd_valid/cmd_stall) and results leave on rsp
// (rsp_valid/rsp_stall). A command is taken when cmd_valid is high and
// cmd_stall is low; the machine works on one command at a time and raises
// cmd_stall until its last result has gone into the output register.
// A load, a clear or a card byte that is not stored answers from the dispatch
// state; a stored card byte reads its word there and rewrites it in the card
// state. An execute during a card read or with the counter outside memory also
// answers from dispatch. Any other execute reads the instruction in dispatch and
// decodes it in the fetch state; L and C need a second memory read and answer
// from the operand state; S, B, G, unknown operations and operand faults answer
// from fetch. After the fetch and operand read, P streams one byte per cycle
// unless rsp_stall holds it: 4*BLOCK_WORDS bytes, a newline; H gives two newlines.
// Each memory word has a valid bit, so reset and clear take effect at once
// and no clearing pass is needed. While rsp_stall is high and a result waits, the output
// register holds its word and the sequencer waits before producing the next.
module tiny_word_machine_cpu #(
    parameter int MEM_WORDS   = twm_pkg::MEM_WORDS,
    parameter int BLOCK_WORDS = twm_pkg::BLOCK_WORDS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  twm_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output twm_pkg::rsp_t rsp
);

    localparam int AW          = $clog2(MEM_WORDS);
    localparam int BLOCK_BYTES = 4 * BLOCK_WORDS;

    twm_pkg::state_t state_reg, state_next;
    twm_pkg::cmd_t   cmd_reg;
    twm_pkg::rsp_t   rsp_reg, rsp_next;
    logic            rsp_valid_reg, rsp_valid_next;

    logic [6:0]      ic_reg, ic_next;
    logic [31:0]     r_reg, r_next;
    logic            flag_reg, flag_next;
    logic            wait_reg, wait_next;
    logic [6:0]      base_reg, base_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic [6:0]      ptr_reg, ptr_next;
    logic [5:0]      pk_reg, pk_next;
    logic            ld_reg, ld_next;
    logic [MEM_WORDS-1:0] vld_reg;
    logic [AW-1:0]   rd_addr_reg;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [31:0]     ram_wdata, ram_q, mem_q;

    logic            go, emit, clr;
    logic            pv, lst, hlt, flt;
    logic [7:0]      pb;

    logic [7:0]      ins_op, ins_hi, ins_lo;
    logic            known_op, digits_ok, opd_ok, blk_ok;
    logic [6:0]      dec, ic_inc;
    logic [7:0]      prt_byte;
    logic [31:0]     card_word;

    twm_ram #(
        .W (32),
        .D (MEM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .q     (ram_q)
    );

    // Words never written since the last clear read as zero.
    assign mem_q = vld_reg[rd_addr_reg] ? ram_q : 32'd0;

    assign ins_op    = mem_q[31:24];
    assign ins_hi    = mem_q[15:8];
    assign ins_lo    = mem_q[7:0];
    assign known_op  = (ins_op == twm_pkg::CH_L) || (ins_op == twm_pkg::CH_S) ||
                       (ins_op == twm_pkg::CH_C) || (ins_op == twm_pkg::CH_B) ||
                       (ins_op == twm_pkg::CH_G) || (ins_op == twm_pkg::CH_P);
    assign digits_ok = (ins_hi >= twm_pkg::CH_ZERO) && (ins_hi <= twm_pkg::CH_NINE) &&
                       (ins_lo >= twm_pkg::CH_ZERO) && (ins_lo <= twm_pkg::CH_NINE);
    assign dec       = {ins_hi[3:0], 3'b000} + {2'b00, ins_hi[3:0], 1'b0}
                       + {3'b000, ins_lo[3:0]};
    assign opd_ok    = digits_ok && (dec < 7'(MEM_WORDS));
    assign blk_ok    = ({1'b0, dec} + 8'(BLOCK_WORDS)) <= 8'(MEM_WORDS);
    assign ic_inc    = ic_reg + 7'd1;

    always_comb
    begin
        case (pk_reg[1:0])
            2'd0:    prt_byte = mem_q[31:24];
            2'd1:    prt_byte = mem_q[23:16];
            2'd2:    prt_byte = mem_q[15:8];
            default: prt_byte = mem_q[7:0];
        endcase
    end

    always_comb
    begin
        card_word = mem_q;
        case (cnt_reg[1:0])
            2'd0:    card_word[31:24] = cmd_reg.card_byte;
            2'd1:    card_word[23:16] = cmd_reg.card_byte;
            2'd2:    card_word[15:8]  = cmd_reg.card_byte;
            default: card_word[7:0]   = cmd_reg.card_byte;
        endcase
    end

    assign cmd_stall = (state_reg != twm_pkg::ST_IDLE);
    assign go        = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        ic_next    = ic_reg;
        r_next     = r_reg;
        flag_next  = flag_reg;
        wait_next  = wait_reg;
        base_next  = base_reg;
        cnt_next   = cnt_reg;
        ptr_next   = ptr_reg;
        pk_next    = pk_reg;
        ld_next    = ld_reg;
        emit       = 1'b0;
        clr        = 1'b0;
        pv         = 1'b0;
        pb         = 8'd0;
        lst        = 1'b1;
        hlt        = 1'b0;
        flt        = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = r_reg;
        ram_re     = 1'b0;
        ram_raddr  = '0;

        unique case (state_reg)
            twm_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = twm_pkg::ST_DISPATCH;
                end
            end
            twm_pkg::ST_DISPATCH:
            begin
                unique case (cmd_reg.opcode)
                    twm_pkg::OPC_LOAD:
                    begin
                        if (go)
                        begin
                            emit = 1'b1;
                            if (cmd_reg.address < 7'(MEM_WORDS))
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(cmd_reg.address);
                                ram_wdata = cmd_reg.word;
                            end
                            else
                            begin
                                flt = 1'b1;
                            end
                            state_next = twm_pkg::ST_IDLE;
                        end
                    end
                    twm_pkg::OPC_EXEC:
                    begin
                        if (wait_reg || (ic_reg >= 7'(MEM_WORDS)))
                        begin
                            if (go)
                            begin
                                emit       = 1'b1;
                                flt        = !wait_reg;
                                state_next = twm_pkg::ST_IDLE;
                            end
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = AW'(ic_reg);
                            state_next = twm_pkg::ST_FETCH;
                        end
                    end
                    twm_pkg::OPC_CARD:
                    begin
                        if (wait_reg && (cmd_reg.card_byte != twm_pkg::CH_NEWLINE) &&
                            (cnt_reg < 6'(BLOCK_BYTES)))
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = AW'(base_reg + {3'b000, cnt_reg[5:2]});
                            state_next = twm_pkg::ST_CARD;
                        end
                        else if (go)
                        begin
                            emit = 1'b1;
                            if (cmd_reg.card_byte == twm_pkg::CH_NEWLINE)
                            begin
                                wait_next = 1'b0;
                            end
                            state_next = twm_pkg::ST_IDLE;
                        end
                    end
                    default:
                    begin
                        if (go)
                        begin
                            emit       = 1'b1;
                            clr        = 1'b1;
                            state_next = twm_pkg::ST_IDLE;
                        end
                    end
                endcase
            end
            twm_pkg::ST_FETCH:
            begin
                if (ins_op == twm_pkg::CH_H)
                begin
                    if (go)
                    begin
                        emit       = 1'b1;
                        clr        = 1'b1;
                        pv         = 1'b1;
                        pb         = twm_pkg::CH_NEWLINE;
                        lst        = 1'b0;
                        hlt        = 1'b1;
                        state_next = twm_pkg::ST_HALT_NL;
                    end
                end
                else if (!known_op || !opd_ok ||
                         (((ins_op == twm_pkg::CH_G) || (ins_op == twm_pkg::CH_P)) && !blk_ok))
                begin
                    if (go)
                    begin
                        emit       = 1'b1;
                        flt        = known_op;
                        ic_next    = ic_inc;
                        state_next = twm_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    case (ins_op) inside
                        twm_pkg::CH_L, twm_pkg::CH_C:
                        begin
                            ic_next    = ic_inc;
                            ld_next    = (ins_op == twm_pkg::CH_L);
                            ram_re     = 1'b1;
                            ram_raddr  = AW'(dec);
                            state_next = twm_pkg::ST_OPER;
                        end
                        twm_pkg::CH_P:
                        begin
                            ic_next    = ic_inc;
                            ptr_next   = dec;
                            pk_next    = 6'd0;
                            ram_re     = 1'b1;
                            ram_raddr  = AW'(dec);
                            state_next = twm_pkg::ST_PRINT;
                        end
                        twm_pkg::CH_S:
                        begin
                            if (go)
                            begin
                                emit       = 1'b1;
                                ic_next    = ic_inc;
                                ram_we     = 1'b1;
                                ram_waddr  = AW'(dec);
                                state_next = twm_pkg::ST_IDLE;
                            end
                        end
                        twm_pkg::CH_B:
                        begin
                            if (go)
                            begin
                                emit = 1'b1;
                                if (flag_reg)
                                begin
                                    ic_next   = dec;
                                    flag_next = 1'b0;
                                end
                                else
                                begin
                                    ic_next = ic_inc;
                                end
                                state_next = twm_pkg::ST_IDLE;
                            end
                        end
                        twm_pkg::CH_G:
                        begin
                            if (go)
                            begin
                                emit       = 1'b1;
                                ic_next    = ic_inc;
                                wait_next  = 1'b1;
                                base_next  = dec;
                                cnt_next   = 6'd0;
                                state_next = twm_pkg::ST_IDLE;
                            end
                        end
                        default:
                        begin
                            state_next = twm_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            twm_pkg::ST_OPER:
            begin
                if (go)
                begin
                    emit = 1'b1;
                    if (ld_reg)
                    begin
                        r_next = mem_q;
                    end
                    else
                    begin
                        flag_next = (mem_q == r_reg);
                    end
                    state_next = twm_pkg::ST_IDLE;
                end
            end
            twm_pkg::ST_PRINT:
            begin
                if (go)
                begin
                    emit    = 1'b1;
                    pv      = 1'b1;
                    pb      = prt_byte;
                    lst     = 1'b0;
                    pk_next = pk_reg + 6'd1;
                    if (pk_reg == 6'(BLOCK_BYTES - 1))
                    begin
                        state_next = twm_pkg::ST_PRINT_NL;
                    end
                    else if (pk_reg[1:0] == 2'd3)
                    begin
                        ptr_next  = ptr_reg + 7'd1;
                        ram_re    = 1'b1;
                        ram_raddr = AW'(ptr_reg + 7'd1);
                    end
                end
            end
            twm_pkg::ST_PRINT_NL:
            begin
                if (go)
                begin
                    emit       = 1'b1;
                    pv         = 1'b1;
                    pb         = twm_pkg::CH_NEWLINE;
                    state_next = twm_pkg::ST_IDLE;
                end
            end
            twm_pkg::ST_HALT_NL:
            begin
                if (go)
                begin
                    emit       = 1'b1;
                    pv         = 1'b1;
                    pb         = twm_pkg::CH_NEWLINE;
                    hlt        = 1'b1;
                    state_next = twm_pkg::ST_IDLE;
                end
            end
            twm_pkg::ST_CARD:
            begin
                if (go)
                begin
                    emit       = 1'b1;
                    ram_we     = 1'b1;
                    ram_waddr  = rd_addr_reg;
                    ram_wdata  = card_word;
                    cnt_next   = cnt_reg + 6'd1;
                    state_next = twm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = twm_pkg::ST_IDLE;
            end
        endcase

        if (clr)
        begin
            ic_next   = 7'd0;
            r_next    = 32'd0;
            flag_next = 1'b0;
            wait_next = 1'b0;
            base_next = 7'd0;
            cnt_next  = 6'd0;
        end

        rsp_next = '{
            printer_valid:  pv,
            printer_byte:   pb,
            last:           lst,
            halted:         hlt,
            waiting_card:   wait_next,
            fault:          flt,
            counter_value:  ic_next,
            flag_value:     flag_next,
            register_value: r_next
        };

        if (emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= twm_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
            ic_reg        <= 7'd0;
            r_reg         <= 32'd0;
            flag_reg      <= 1'b0;
            wait_reg      <= 1'b0;
            base_reg      <= 7'd0;
            cnt_reg       <= 6'd0;
            vld_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            ic_reg        <= ic_next;
            r_reg         <= r_next;
            flag_reg      <= flag_next;
            wait_reg      <= wait_next;
            base_reg      <= base_next;
            cnt_reg       <= cnt_next;
            if (clr)
            begin
                vld_reg <= '0;
            end
            else if (ram_we)
            begin
                vld_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            cmd_reg <= cmd;
        end
        if (emit)
        begin
            rsp_reg <= rsp_next;
        end
        if (ram_re)
        begin
            rd_addr_reg <= ram_raddr;
        end
        ptr_reg <= ptr_next;
        pk_reg  <= pk_next;
        ld_reg  <= ld_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ src/twm_checker.sv @@
// Port-level checks for the tiny word machine, bound to the top level.
// Depends on twm_pkg and tiny_word_machine_cpu.
module twm_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_stall,
    input twm_pkg::cmd_t cmd,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input twm_pkg::rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("Stalled result word changed.");

    a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.printer_valid |-> rsp.last && (rsp.printer_byte == 8'd0))
        else $error("Status word is not a final zero-byte word.");

    a_fault_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.fault |-> !rsp.printer_valid && !rsp.halted)
        else $error("Fault word carries printer output.");

    a_halt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.halted |-> rsp.printer_valid &&
            (rsp.printer_byte == twm_pkg::CH_NEWLINE) && (rsp.counter_value == 7'd0) &&
            !rsp.flag_value && !rsp.waiting_card && (rsp.register_value == 32'd0))
        else $error("Halt word does not show a cleared machine.");

endmodule

bind tiny_word_machine_cpu twm_checker u_twm_checker (.*);
